### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sidp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidp_pkg
// Types, constants and helpers shared by the scaled int4 dot product block.
// ----------------------------------------------------------------------------
package sidp_pkg;

  localparam int ACC_W                     = 64;
  localparam int ACC_FRACTION_BITS_DEFAULT = 24;
  localparam int QUEUE_DEPTH_DEFAULT       = 4;
  // Holds the sum of two scale exponents and the fraction bits over the full
  // fraction-bit range of 16 to 30.
  localparam int EXP_W  = 7;
  localparam int PROD_W = 8;
  localparam int MAG_W  = 7;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [3:0] a_value;
    logic [7:0] a_scale;
    logic [3:0] b_value;
    logic [7:0] b_scale;
    logic [7:0] row_scale;
    logic [7:0] col_scale;
    logic       last_element;
  } pair_t;

  typedef struct packed {
    logic [3:0] out_value;
    logic [7:0] result_scale;
  } result_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] term;
    logic                    last;
    logic [7:0]              result_scale;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic signed [5:0] scale_to_exp(input logic [7:0] s);
    logic signed [5:0] e;
    e = $signed({2'b00, s[3:0]});
    return s[7] ? -e : e;
  endfunction

endpackage

### hw/rtl/scaled_int4_dot_product.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_int4_dot_product
// Block-scaled int4 dot product with a saturating fixed-point accumulator and
// a rounded, clamped int4 result per row/column pair.
//
//   Channel   Direction   Handshake                   Payload
//   pair      in          pair_valid / pair_stall     pair_t
//   result    out         result_valid / result_stall result_t
//
// One pair is accepted in every cycle while the queue has room.
// A result follows its last pair through the front register, the queue, the
// accumulator and quantize register, then the output register.
// Reset clears the accumulator, the queue and all valid flags.
// A stalled result backs up into the queue, which then stalls the pair channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scaled_int4_dot_product import sidp_pkg::*; #(
  parameter int ACC_FRACTION_BITS = ACC_FRACTION_BITS_DEFAULT,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    pair_valid,
  output logic    pair_stall,
  input  pair_t   pair,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic          push;
  logic          pop;
  entry_t        push_data;
  entry_t        head;
  queue_status_t qstat;

  sidp_front #(
    .ACC_FRACTION_BITS(ACC_FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pair_valid(pair_valid),
    .pair_stall(pair_stall),
    .pair      (pair),
    .push      (push),
    .push_data (push_data),
    .qstat     (qstat)
  );

  sidp_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  sidp_back #(
    .ACC_FRACTION_BITS(ACC_FRACTION_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  `ASSERT_IMP(a_no_overflow, push, !qstat.full, "Push into a full queue.")
  `ASSERT_IMP(a_no_underflow, pop, !qstat.empty, "Pop from an empty queue.")
  `ASSERT_NXT(a_push_fills, push, !qstat.empty, "Queue empty after a push.")
  `ASSERT_IMP(a_clamped, result_valid, result.out_value != 4'h8, "Result below -7.")

endmodule

### hw/rtl/sidp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidp_front
// Accepts operand pairs, decodes nibbles and scales, and forms the signed
// fixed-point product term that is pushed into the queue.
// ----------------------------------------------------------------------------
module sidp_front import sidp_pkg::*; #(
  parameter int ACC_FRACTION_BITS = ACC_FRACTION_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pair_valid,
  output logic          pair_stall,
  input  pair_t         pair,
  output logic          push,
  output entry_t        push_data,
  input  queue_status_t qstat
);

  logic                     f_valid;
  logic                     f_free;
  logic signed [PROD_W-1:0] prod;
  logic signed [EXP_W-1:0]  texp;
  logic                     last;
  logic [7:0]               oscale;

  logic signed [3:0]        av;
  logic signed [3:0]        bv;
  logic signed [5:0]        ea;
  logic signed [5:0]        eb;
  logic [8:0]               scale_sum;

  logic                     neg;
  logic [PROD_W-1:0]        pa;
  logic [MAG_W-1:0]         m;
  logic [5:0]               lsh;
  logic [MAG_W+62:0]        wide;
  logic [EXP_W-1:0]         rsh;
  logic [MAG_W:0]           rext;
  logic [MAG_W-1:0]         rq;
  logic                     big;
  logic [ACC_W-1:0]         mag;

  assign f_free     = !f_valid || !qstat.full;
  assign pair_stall = !f_free;
  assign push       = f_valid && !qstat.full;

  assign av        = pair.a_value;
  assign bv        = pair.b_value;
  assign ea        = scale_to_exp(pair.a_scale);
  assign eb        = scale_to_exp(pair.b_scale);
  assign scale_sum = {1'b0, pair.row_scale} + {1'b0, pair.col_scale};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_free) begin
      f_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_free && pair_valid) begin
      prod   <= $signed({{4{av[3]}}, av}) * $signed({{4{bv[3]}}, bv});
      texp   <= EXP_W'(ea) + EXP_W'(eb) + EXP_W'(ACC_FRACTION_BITS);
      last   <= pair.last_element;
      oscale <= scale_sum[8:1];
    end
  end

  always_comb begin
    neg  = prod[PROD_W-1];
    pa   = neg ? PROD_W'(-prod) : PROD_W'(prod);
    m    = pa[MAG_W-1:0];
    lsh  = texp[5:0];
    wide = {{63{1'b0}}, m} << lsh;
    rsh  = EXP_W'(-texp);
    rext = {m, 1'b0} >> rsh;
    rq   = rext[MAG_W:1] + MAG_W'(rext[0]);
    big  = 1'b0;
    mag  = '0;
    if (m == '0) begin
      mag = '0;
    end else if (!texp[EXP_W-1]) begin
      big = (lsh == 6'h3F) || (|wide[MAG_W+62:63]);
      mag = wide[ACC_W-1:0];
    end else begin
      mag = ACC_W'(rq);
    end
    push_data.last         = last;
    push_data.result_scale = oscale;
    if (big) begin
      push_data.term = neg ? ACC_MIN : ACC_MAX;
    end else begin
      push_data.term = neg ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

### hw/rtl/sidp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidp_queue
// Short first-in first-out queue of product terms between front and back.
// ----------------------------------------------------------------------------
module sidp_queue import sidp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  entry_t        push_data,
  input  logic          pop,
  output entry_t        head,
  output queue_status_t qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        2'b11: count <= count;
        2'b00: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/sidp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidp_back
// Saturating accumulation of product terms, then rounding and clamping of the
// finished sum to a signed nibble held in the output register.
// ----------------------------------------------------------------------------
module sidp_back import sidp_pkg::*; #(
  parameter int ACC_FRACTION_BITS = ACC_FRACTION_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  entry_t        head,
  input  queue_status_t qstat,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output result_t       result
);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic [ACC_W:0]          sum_ext;
  logic                    ovf;

  logic                    q_valid;
  logic                    q_free;
  logic                    out_free;
  logic signed [ACC_W-1:0] q_sum;
  logic [7:0]              q_scale;

  logic                    q_neg;
  logic [ACC_W-1:0]        sm;
  logic signed [EXP_W-1:0] ksh;
  logic [ACC_W-1:0]        t1;
  logic [3:0]              q4;
  logic [2:0]              qmag;
  logic [3:0]              qval;

  assign out_free = !result_valid || !result_stall;
  assign q_free   = !q_valid || out_free;
  assign pop      = !qstat.empty && (!head.last || q_free);

  always_comb begin
    sum_ext = {acc[ACC_W-1], acc} + {head.term[ACC_W-1], head.term};
    ovf     = sum_ext[ACC_W] != sum_ext[ACC_W-1];
    if (ovf) begin
      acc_next = sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = sum_ext[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (pop) begin
      acc <= head.last ? '0 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (q_free) begin
      q_valid <= pop && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      q_sum   <= acc_next;
      q_scale <= head.result_scale;
    end
  end

  always_comb begin
    q_neg = q_sum[ACC_W-1];
    sm    = q_neg ? ACC_W'(-q_sum) : ACC_W'(q_sum);
    ksh   = EXP_W'(ACC_FRACTION_BITS - 1) + EXP_W'(scale_to_exp(q_scale));
    t1    = sm >> ksh[EXP_W-1:0];
    q4    = t1[3:0] + 4'd1;
    qmag  = (t1 >= ACC_W'(14)) ? 3'd7 : q4[3:1];
    qval  = q_neg ? 4'(-{1'b0, qmag}) : {1'b0, qmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && q_valid) begin
      result.out_value    <= qval;
      result.result_scale <= q_scale;
    end
  end

endmodule

### verif/dot_product_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_product_checker
// Watches the pair and result channels of the scaled int4 dot product block.
// Every accepted pair is run through a local model of the fixed-point
// accumulator. A pair marked last queues the rounded, clamped int4 result.
// Every accepted result is compared field by field with the oldest queued
// result, and mismatches are counted.
// ----------------------------------------------------------------------------
module dot_product_checker import sidp_pkg::*; #(
  parameter int FRAC_BITS = ACC_FRACTION_BITS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    pair_valid,
  input  logic    pair_stall,
  input  pair_t   pair,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      errors,
  output int      pending
);

  logic signed [ACC_W-1:0] sum_q = '0;
  result_t                 expected_results[$];
  result_t                 want;
  int                      err_count  = 0;
  int                      pend_count = 0;

  assign errors  = err_count;
  assign pending = pend_count;

  function automatic int exp_of_scale(input logic [7:0] s);
    int e;
    e = int'(s[3:0]);
    return s[7] ? -e : e;
  endfunction

  function automatic logic [63:0] round_half_away(input logic [63:0] m, input int k);
    logic [63:0] q;
    q = m >> k;
    if (m[k-1])
      q = q + 64'd1;
    return q;
  endfunction

  function automatic logic signed [ACC_W-1:0] term_of_pair(input pair_t p);
    int          av;
    int          bv;
    int          prod;
    int          t;
    logic        neg;
    logic [63:0] m;
    logic [63:0] mag;
    av   = $signed(p.a_value);
    bv   = $signed(p.b_value);
    prod = av * bv;
    neg  = prod < 0;
    m    = neg ? 64'(-prod) : 64'(prod);
    t    = exp_of_scale(p.a_scale) + exp_of_scale(p.b_scale) + FRAC_BITS;
    if (m == 64'd0)
      mag = 64'd0;
    else if (t >= 0) begin
      if (t >= 63 || m > (64'd1 << (63 - t)))
        mag = 64'h8000_0000_0000_0000;
      else
        mag = m << t;
    end else
      mag = round_half_away(m, -t);
    if (neg) begin
      if (mag[63])
        return ACC_MIN;
      return -$signed(mag);
    end
    if (mag[63])
      return ACC_MAX;
    return $signed(mag);
  endfunction

  function automatic logic signed [ACC_W-1:0] add_saturating(
    input logic signed [ACC_W-1:0] x,
    input logic signed [ACC_W-1:0] y
  );
    logic signed [ACC_W:0] wide;
    wide = {x[ACC_W-1], x} + {y[ACC_W-1], y};
    if (wide[ACC_W] != wide[ACC_W-1])
      return wide[ACC_W] ? ACC_MIN : ACC_MAX;
    return wide[ACC_W-1:0];
  endfunction

  function automatic result_t quantize_sum(
    input logic signed [ACC_W-1:0] s,
    input logic [7:0]              row,
    input logic [7:0]              col
  );
    result_t     r;
    logic [8:0]  total;
    logic        neg;
    logic [63:0] sm;
    logic [63:0] q;
    int          k;
    total          = {1'b0, row} + {1'b0, col};
    r.result_scale = total[8:1];
    k              = FRAC_BITS + exp_of_scale(r.result_scale);
    neg            = s < 0;
    sm             = neg ? (64'd0 - 64'(s)) : 64'(s);
    q              = round_half_away(sm, k);
    if (q > 64'd7)
      q = 64'd7;
    r.out_value = neg ? (4'd0 - q[3:0]) : q[3:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sum_q = '0;
      expected_results.delete();
    end else begin
      if (pair_valid && !pair_stall) begin
        sum_q = add_saturating(sum_q, term_of_pair(pair));
        if (pair.last_element) begin
          expected_results.push_back(quantize_sum(sum_q, pair.row_scale, pair.col_scale));
          sum_q = '0;
        end
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: out_value %0h result_scale %0h",
                 result.out_value, result.result_scale);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.out_value !== want.out_value) begin
            $error("out_value: expected %0h, actual %0h", want.out_value, result.out_value);
            err_count++;
          end
          if (result.result_scale !== want.result_scale) begin
            $error("result_scale: expected %0h, actual %0h", want.result_scale,
                   result.result_scale);
            err_count++;
          end
        end
      end
    end
    pend_count = expected_results.size();
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the scaled int4 dot product block with directed corner pairs, a
// back-pressure burst and random dot products of random length, with random
// gaps on the pair channel and random stalls on the result channel. Checking
// is done by the checker instance, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import sidp_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 16;

  logic    clk;
  logic    rst;
  logic    pair_valid;
  logic    pair_stall;
  pair_t   pair;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      errors;
  int      pending;

  bit      steady;
  bit      hold_off_req;
  int      items_sent;

  scaled_int4_dot_product DUT (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .pair         (pair),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  dot_product_checker #(
    .FRAC_BITS (ACC_FRACTION_BITS_DEFAULT)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .pair         (pair),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_scale(input bit wide);
    logic [7:0] s;
    s = 8'($urandom_range(0, 255));
    if (!wide)
      s[3:0] = 4'($urandom_range(0, 4));
    return s;
  endfunction

  task automatic send_pair(input pair_t p);
    int idle;
    idle = steady ? 0 : gap_cycles();
    if (idle > 0) begin
      pair_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    pair       <= p;
    pair_valid <= 1'b1;
    do @(posedge clk); while (pair_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_fields(
    input logic [3:0] av, input logic [7:0] as, input logic [3:0] bv,
    input logic [7:0] bs, input logic [7:0] row, input logic [7:0] col,
    input logic       last
  );
    pair_t p;
    p.a_value      = av;
    p.a_scale      = as;
    p.b_value      = bv;
    p.b_scale      = bs;
    p.row_scale    = row;
    p.col_scale    = col;
    p.last_element = last;
    send_pair(p);
  endtask

  task automatic send_random_dot();
    int         len;
    bit         wide;
    pair_t      p;
    logic [7:0] os;
    len  = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    wide = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      p.a_value      = 4'($urandom_range(0, 15));
      p.a_scale      = rand_scale(wide);
      p.b_value      = 4'($urandom_range(0, 15));
      p.b_scale      = rand_scale(wide);
      p.row_scale    = 8'($urandom_range(0, 255));
      p.col_scale    = 8'($urandom_range(0, 255));
      p.last_element = (i == len - 1);
      if (p.last_element && $urandom_range(0, 1)) begin
        os          = rand_scale(1'b0);
        p.row_scale = os;
        p.col_scale = os;
      end
      send_pair(p);
    end
  endtask

  // Result side: random stalls, a long hold-off on request, none while steady.
  initial begin
    bit s;
    int n;
    result_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        s = 1'b1;
        n = HOLD_CYCLES;
      end else if (steady) begin
        s = 1'b0;
        n = 1;
      end else begin
        s = ($urandom_range(0, 2) == 0);
        n = s ? gap_cycles() + 1 : $urandom_range(1, 8);
      end
      result_stall <= s;
      repeat (n) @(negedge clk);
    end
  end

  initial begin
    pair_pkt_init: begin
      pair       = '0;
      pair_valid = 1'b0;
    end
    steady       = 1'b0;
    hold_off_req = 1'b0;
    items_sent   = 0;
    rst          = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_fields(4'h7, 8'h0F, 4'h7, 8'h0F, 8'h00, 8'h00, 1'b0);
    send_fields(4'h7, 8'h0F, 4'h7, 8'h0F, 8'h00, 8'h00, 1'b1);
    send_fields(4'h8, 8'h0F, 4'h7, 8'h0F, 8'h00, 8'h00, 1'b0);
    send_fields(4'h8, 8'h0F, 4'h7, 8'h0F, 8'hFF, 8'hFF, 1'b1);
    send_fields(4'h8, 8'h8F, 4'h8, 8'h8F, 8'hA5, 8'h3C, 1'b0);
    send_fields(4'h7, 8'h8F, 4'h8, 8'h8F, 8'h00, 8'h00, 1'b1);
    send_fields(4'h2, 8'h8F, 4'h1, 8'h8A, 8'h8F, 8'h8F, 1'b1);
    send_fields(4'h1, 8'h81, 4'h1, 8'h00, 8'h00, 8'h00, 1'b1);
    send_fields(4'hF, 8'h81, 4'h1, 8'h70, 8'h01, 8'h00, 1'b1);
    send_fields(4'h1, 8'hF1, 4'h1, 8'hF1, 8'hFF, 8'hFE, 1'b1);
    send_fields(4'h0, 8'hFF, 4'h9, 8'h0F, 8'h12, 8'h34, 1'b1);
    send_fields(4'h7, 8'h07, 4'h7, 8'h07, 8'h0E, 8'h10, 1'b1);
    send_fields(4'h3, 8'h00, 4'h5, 8'h00, 8'h04, 8'h04, 1'b1);
    send_fields(4'h8, 8'h00, 4'h8, 8'h00, 8'h06, 8'h06, 1'b1);
    send_fields(4'h8, 8'h00, 4'h1, 8'h00, 8'h07, 8'h07, 1'b1);
    send_fields(4'hC, 8'h02, 4'h3, 8'h01, 8'h81, 8'h83, 1'b1);
    send_fields(4'h5, 8'h70, 4'hA, 8'hF3, 8'h7F, 8'h80, 1'b1);

    steady       = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_fields(4'($urandom_range(0, 15)), rand_scale(1'b0), 4'($urandom_range(0, 15)),
                  rand_scale(1'b0), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b1);
    steady = 1'b0;
    pair_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent % 100 < 8)
        steady = ($urandom_range(0, 3) == 0);
      send_random_dot();
      if ($urandom_range(0, 39) == 0) begin
        pair_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
    end
    pair_valid <= 1'b0;
    steady     = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

### scaled_int4_dot_product.f
+incdir+hw/rtl
hw/rtl/sidp_pkg.sv
hw/rtl/sidp_front.sv
hw/rtl/sidp_queue.sv
hw/rtl/sidp_back.sv
hw/rtl/scaled_int4_dot_product.sv
verif/dot_product_checker.sv
verif/tb_top.sv
